FILE: src/dpb_pkg.sv
package dpb_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_DEPTH_SCALE = 3'd4
    } reg_index_t;

    localparam logic [19:0] FOCAL_X_RST     = 20'd153600;
    localparam logic [19:0] FOCAL_Y_RST     = 20'd153600;
    localparam logic [15:0] CENTER_X_RST    = 16'd5120;
    localparam logic [15:0] CENTER_Y_RST    = 16'd3840;
    localparam logic [15:0] DEPTH_SCALE_RST = 16'd1000;

    localparam int CFG_W   = 20;
    localparam int ZW      = 19;   // quotient bits of the depth division
    localparam int ZREM    = 36;   // remainder width of the depth division
    localparam int LW      = 24;   // quotient bits of the lateral division
    localparam int LREM    = 46;   // remainder width of the lateral division
    localparam int LATENCY = ZW + LW + 4;

    localparam logic [ZW-1:0] Z_MAX     = 19'd425984;
    localparam logic [LW-1:0] Q_POS_MAX = 24'd8388607;
    localparam logic [LW-1:0] Q_NEG_MAX = 24'd8388608;

    typedef struct packed {
        logic [15:0] pixel_u;
        logic [15:0] pixel_v;
        logic [15:0] depth_raw;
    } request_t;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [18:0]        point_z;
        logic               has_depth;
    } result_t;

    // Per-item side data that travels down the pipeline.
    typedef struct packed {
        logic        ok;
        logic        neg_x;
        logic        neg_y;
        logic [16:0] mag_x;
        logic [16:0] mag_y;
    } lane_t;

endpackage

FILE: src/depth_pixel_backprojection_top.sv
// Channel   Ports                         Handshake
// request   start, busy, request          taken when start is high and busy is low
// result    done, result                  valid for the single cycle done is high
// config    cfg_we, cfg_index, cfg_data   written at every edge with cfg_we high
//
// One request is taken every cycle; busy is always low.
// Each result passes through one entry stage,
// 19 restoring-division stages for depth, a multiply stage, a setup stage,
// 24 restoring-division stages for x and y side by side, and an output stage.
// Reset clears the valid bits and loads the register defaults; the result side
// takes every result as offered.
module depth_pixel_backprojection_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dpb_pkg::request_t               request,
    output logic                            done,
    output dpb_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [dpb_pkg::CFG_W-1:0]       cfg_data
);

    localparam int ZW   = dpb_pkg::ZW;
    localparam int ZREM = dpb_pkg::ZREM;
    localparam int LW   = dpb_pkg::LW;
    localparam int LREM = dpb_pkg::LREM;

    logic [19:0] focal_x_reg;
    logic [19:0] focal_y_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [15:0] depth_scale_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg     <= dpb_pkg::FOCAL_X_RST;
            focal_y_reg     <= dpb_pkg::FOCAL_Y_RST;
            center_x_reg    <= dpb_pkg::CENTER_X_RST;
            center_y_reg    <= dpb_pkg::CENTER_Y_RST;
            depth_scale_reg <= dpb_pkg::DEPTH_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dpb_pkg::REG_FOCAL_X:     focal_x_reg     <= cfg_data;
                dpb_pkg::REG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                dpb_pkg::REG_CENTER_X:    center_x_reg    <= cfg_data[15:0];
                dpb_pkg::REG_CENTER_Y:    center_y_reg    <= cfg_data[15:0];
                dpb_pkg::REG_DEPTH_SCALE: depth_scale_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // A zero focal length acts as one.
    logic [19:0] fx_eff;
    logic [19:0] fy_eff;
    assign fx_eff = (focal_x_reg == 20'd0) ? 20'd1 : focal_x_reg;
    assign fy_eff = (focal_y_reg == 20'd0) ? 20'd1 : focal_y_reg;

    // Entry: round pixels, form offsets, depth range test and depth numerator.
    logic [12:0]        pu;
    logic [12:0]        pv;
    logic signed [17:0] dxs;
    logic signed [17:0] dys;
    logic [17:0]        raw2;
    logic [19:0]        s13;
    dpb_pkg::lane_t     entry_lane;
    logic [ZREM-1:0]    entry_num;

    always_comb
    begin
        pu   = 13'(({1'b0, request.pixel_u} + 17'd8) >> 4);
        pv   = 13'(({1'b0, request.pixel_v} + 17'd8) >> 4);
        dxs  = $signed({1'b0, pu, 4'b0}) - $signed({2'b0, center_x_reg});
        dys  = $signed({1'b0, pv, 4'b0}) - $signed({2'b0, center_y_reg});
        raw2 = {1'b0, request.depth_raw, 1'b0};
        s13  = 20'(depth_scale_reg) * 20'd13;
        entry_lane.ok    = (depth_scale_reg != 16'd0) && (raw2 >= 18'(depth_scale_reg))
                           && (20'(raw2) <= s13);
        entry_lane.neg_x = dxs[17];
        entry_lane.neg_y = dys[17];
        entry_lane.mag_x = dxs[17] ? 17'(-dxs) : dxs[16:0];
        entry_lane.mag_y = dys[17] ? 17'(-dys) : dys[16:0];
        entry_num        = {3'b0, request.depth_raw, 17'b0} + ZREM'(depth_scale_reg);
    end

    // Depth division pipeline: one quotient bit per stage.
    logic               zv_reg   [0:ZW];
    dpb_pkg::lane_t     zl_reg   [0:ZW];
    logic [ZREM-1:0]    zr_reg   [0:ZW];
    logic [ZW-1:0]      zq_reg   [0:ZW];
    logic [ZREM-1:0]    zr_next  [0:ZW-1];
    logic [ZW-1:0]      zq_next  [0:ZW-1];
    logic [ZREM-1:0]    zdiv;

    assign zdiv = ZREM'({depth_scale_reg, 1'b0});

    always_comb
    begin
        for (int k = 0; k < ZW; k++)
        begin
            logic [ZREM:0] trial;
            trial = {1'b0, zr_reg[k]} - {1'b0, zdiv << (ZW - 1 - k)};
            zq_next[k] = zq_reg[k];
            if (!trial[ZREM])
            begin
                zr_next[k] = trial[ZREM-1:0];
                zq_next[k][ZW-1-k] = 1'b1;
            end
            else
            begin
                zr_next[k] = zr_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ZW; k++)
            begin
                zv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            zv_reg[0] <= start && !busy;
            for (int k = 0; k < ZW; k++)
            begin
                zv_reg[k+1] <= zv_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        zl_reg[0] <= entry_lane;
        zr_reg[0] <= entry_num;
        zq_reg[0] <= '0;
        for (int k = 0; k < ZW; k++)
        begin
            zl_reg[k+1] <= zl_reg[k];
            zr_reg[k+1] <= zr_next[k];
            zq_reg[k+1] <= zq_next[k];
        end
    end

    // Multiply stage: offset magnitude times depth.
    logic           mv_reg;
    dpb_pkg::lane_t ml_reg;
    logic [ZW-1:0]  mz_reg;
    logic [35:0]    mx_reg;
    logic [35:0]    my_reg;

    always_ff @(posedge clk)
    begin
        ml_reg <= zl_reg[ZW];
        mz_reg <= zq_reg[ZW];
        mx_reg <= 36'(zl_reg[ZW].mag_x) * 36'(zq_reg[ZW]);
        my_reg <= 36'(zl_reg[ZW].mag_y) * 36'(zq_reg[ZW]);
    end

    // Setup stage for the lateral division: rounded numerator and overflow.
    logic [LREM-1:0] nx;
    logic [LREM-1:0] ny;
    logic [LREM-1:0] dvx;
    logic [LREM-1:0] dvy;

    always_comb
    begin
        nx  = LREM'({mx_reg, 5'b0}) + LREM'(fx_eff);
        ny  = LREM'({my_reg, 5'b0}) + LREM'(fy_eff);
        dvx = LREM'({fx_eff, 1'b0});
        dvy = LREM'({fy_eff, 1'b0});
    end

    logic            lv_reg  [0:LW];
    dpb_pkg::lane_t  ll_reg  [0:LW];
    logic [ZW-1:0]   lz_reg  [0:LW];
    logic            ovx_reg [0:LW];
    logic            ovy_reg [0:LW];
    logic [LREM-1:0] rx_reg  [0:LW];
    logic [LREM-1:0] ry_reg  [0:LW];
    logic [LW-1:0]   qx_reg  [0:LW];
    logic [LW-1:0]   qy_reg  [0:LW];
    logic [LREM-1:0] rx_next [0:LW-1];
    logic [LREM-1:0] ry_next [0:LW-1];
    logic [LW-1:0]   qx_next [0:LW-1];
    logic [LW-1:0]   qy_next [0:LW-1];

    // Lateral division stages for x and y.
    always_comb
    begin
        for (int j = 0; j < LW; j++)
        begin
            logic [LREM:0] tx;
            logic [LREM:0] ty;
            tx = {1'b0, rx_reg[j]} - {1'b0, dvx << (LW - 1 - j)};
            ty = {1'b0, ry_reg[j]} - {1'b0, dvy << (LW - 1 - j)};
            qx_next[j] = qx_reg[j];
            qy_next[j] = qy_reg[j];
            rx_next[j] = rx_reg[j];
            ry_next[j] = ry_reg[j];
            if (!tx[LREM])
            begin
                rx_next[j] = tx[LREM-1:0];
                qx_next[j][LW-1-j] = 1'b1;
            end
            if (!ty[LREM])
            begin
                ry_next[j] = ty[LREM-1:0];
                qy_next[j][LW-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            for (int j = 0; j <= LW; j++)
            begin
                lv_reg[j] <= 1'b0;
            end
        end
        else
        begin
            mv_reg    <= zv_reg[ZW];
            lv_reg[0] <= mv_reg;
            for (int j = 0; j < LW; j++)
            begin
                lv_reg[j+1] <= lv_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ll_reg[0]  <= ml_reg;
        lz_reg[0]  <= mz_reg;
        ovx_reg[0] <= nx >= (dvx << LW);
        ovy_reg[0] <= ny >= (dvy << LW);
        rx_reg[0]  <= nx;
        ry_reg[0]  <= ny;
        qx_reg[0]  <= '0;
        qy_reg[0]  <= '0;
        for (int j = 0; j < LW; j++)
        begin
            ll_reg[j+1]  <= ll_reg[j];
            lz_reg[j+1]  <= lz_reg[j];
            ovx_reg[j+1] <= ovx_reg[j];
            ovy_reg[j+1] <= ovy_reg[j];
            rx_reg[j+1]  <= rx_next[j];
            ry_reg[j+1]  <= ry_next[j];
            qx_reg[j+1]  <= qx_next[j];
            qy_reg[j+1]  <= qy_next[j];
        end
    end

    // Output stage: sign, saturation and zeroing of invalid points.
    logic [LW-1:0]    sx;
    logic [LW-1:0]    sy;
    dpb_pkg::result_t result_next;
    dpb_pkg::result_t result_reg;
    logic             done_reg;

    always_comb
    begin
        if (ll_reg[LW].neg_x)
        begin
            sx = (ovx_reg[LW] || qx_reg[LW] > dpb_pkg::Q_NEG_MAX) ? dpb_pkg::Q_NEG_MAX
                 : LW'(-qx_reg[LW]);
        end
        else
        begin
            sx = (ovx_reg[LW] || qx_reg[LW] > dpb_pkg::Q_POS_MAX) ? dpb_pkg::Q_POS_MAX
                 : qx_reg[LW];
        end
        if (ll_reg[LW].neg_y)
        begin
            sy = (ovy_reg[LW] || qy_reg[LW] > dpb_pkg::Q_NEG_MAX) ? dpb_pkg::Q_NEG_MAX
                 : LW'(-qy_reg[LW]);
        end
        else
        begin
            sy = (ovy_reg[LW] || qy_reg[LW] > dpb_pkg::Q_POS_MAX) ? dpb_pkg::Q_POS_MAX
                 : qy_reg[LW];
        end
        if (ll_reg[LW].ok)
        begin
            result_next.point_x   = $signed(sx);
            result_next.point_y   = $signed(sy);
            result_next.point_z   = lz_reg[LW];
            result_next.has_depth = 1'b1;
        end
        else
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lv_reg[LW];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // Every result traces back to a request a fixed latency earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, dpb_pkg::LATENCY))
    else $error("result without matching request");

    // An invalid point carries all-zero coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.has_depth) |->
        (result.point_x == 24'sd0 && result.point_y == 24'sd0 && result.point_z == 19'd0))
    else $error("invalid point has nonzero fields");

    // A valid depth stays within the range limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.has_depth) |-> (result.point_z <= dpb_pkg::Z_MAX))
    else $error("depth beyond range limit");
`endif

endmodule
